[rtl/apr_pkg.sv]
// Shared types and constants for the asymmetric PI regulator.
package apr_pkg;

  localparam int FRAC_BITS = 12;
  localparam int GAIN_W    = 16;
  localparam int SAMP_W    = 16;
  localparam int ERR_W     = SAMP_W + 1;
  localparam int PROD_W    = GAIN_W + ERR_W;
  localparam int DRV_W     = 24;
  localparam int INTEG_W   = 26;
  localparam int SUM_W     = PROD_W + 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_KP_RAISE = 3'd0,
    CFG_KP_LOWER = 3'd1,
    CFG_KI_RAISE = 3'd2,
    CFG_KI_LOWER = 3'd3,
    CFG_OUT_MIN  = 3'd4,
    CFG_OUT_MAX  = 3'd5
  } cfg_idx_t;

  localparam logic CMD_STEP  = 1'b0;
  localparam logic CMD_CLEAR = 1'b1;

  typedef struct packed {
    logic                     command;
    logic signed [SAMP_W-1:0] setpoint;
    logic signed [SAMP_W-1:0] feedback;
  } in_item_t;

  typedef struct packed {
    logic signed [DRV_W-1:0] drive;
    logic                    limited;
  } out_item_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] kp_raise;
    logic signed [GAIN_W-1:0] kp_lower;
    logic signed [GAIN_W-1:0] ki_raise;
    logic signed [GAIN_W-1:0] ki_lower;
    logic signed [DRV_W-1:0]  out_min;
    logic signed [DRV_W-1:0]  out_max;
  } cfg_t;

  typedef struct packed {
    out_item_t                 res;
    logic signed [INTEG_W-1:0] integ;
  } step_res_t;

endpackage

[rtl/apr_step.sv]
// One regulator step: error, gain select, P and I terms, limit check, clear.
module apr_step import apr_pkg::*; (
  input  in_item_t                  item,
  input  cfg_t                      cfg,
  input  logic signed [INTEG_W-1:0] integ,
  output step_res_t                 step
);

  logic signed [ERR_W-1:0]  err;
  logic                     pos;
  logic signed [GAIN_W-1:0] kp;
  logic signed [GAIN_W-1:0] ki;
  logic signed [PROD_W-1:0] p_prod;
  logic signed [PROD_W-1:0] i_prod;
  logic signed [PROD_W-1:0] p_term;
  logic signed [PROD_W-1:0] i_term;
  logic signed [SUM_W-1:0]  icand;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  lo;
  logic signed [SUM_W-1:0]  hi;

  always_comb begin
    err    = ERR_W'(item.setpoint) - ERR_W'(item.feedback);
    pos    = (err > ERR_W'(0));
    kp     = pos ? cfg.kp_raise : cfg.kp_lower;
    ki     = pos ? cfg.ki_raise : cfg.ki_lower;
    p_prod = kp * err;
    i_prod = ki * err;
    // floor shift of the Q21.12 products
    p_term = p_prod >>> FRAC_BITS;
    i_term = i_prod >>> FRAC_BITS;
    icand  = SUM_W'(integ) + SUM_W'(i_term);
    sum    = icand + SUM_W'(p_term);
    lo     = SUM_W'(cfg.out_min);
    hi     = SUM_W'(cfg.out_max);

    step.integ       = integ;
    step.res.limited = 1'b0;
    step.res.drive   = sum[DRV_W-1:0];
    if (item.command == CMD_CLEAR) begin
      step.integ     = '0;
      step.res.drive = '0;
    end else if (sum < lo) begin
      step.res.drive   = cfg.out_min;
      step.res.limited = 1'b1;
    end else if (sum > hi) begin
      step.res.drive   = cfg.out_max;
      step.res.limited = 1'b1;
    end else begin
      step.integ = icand[INTEG_W-1:0];
    end
  end

endmodule

[rtl/asymmetric_pi_regulator_core.sv]
// Top level of the asymmetric PI regulator with conditional integration.
//
//   channel | direction | handshake        | payload
//   --------+-----------+------------------+---------------------------------
//   in_     | input     | in_valid/stall   | in_item_t  command/setpoint/fb
//   out_    | output    | out_valid/stall  | out_item_t drive/limited
//   cfg_    | input     | cfg_we           | cfg_idx, cfg_wdata (24 bits)
//
// One transfer per cycle sustained while out_stall is low. A sample
// is captured in the input register, worked combinationally (two 16x17
// multiplies, two adds and a limit compare) and lands in the result
// register. The integrator updates at the same edge, so the next sample
// sees it. rst_n (synchronous) clears the pipeline valids, integrator
// and config registers. out_stall holds the result register; in_stall
// rises only when both registers are full and the result is not taken.
module asymmetric_pi_regulator_core import apr_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [CFG_DAT_W-1:0] cfg_wdata
);

  cfg_t                      cfg_r;
  logic                      s1_valid_r;
  in_item_t                  s1_item_r;
  logic                      out_valid_r;
  out_item_t                 out_item_r;
  logic signed [INTEG_W-1:0] integ_r;

  step_res_t                 step;
  logic                      advance;
  logic                      in_xfer;

  // stage 1 moves into the result register when that slot is free or drained
  assign advance  = s1_valid_r & (~out_valid_r | ~out_stall);
  assign in_stall = s1_valid_r & ~advance;
  assign in_xfer  = in_valid & ~in_stall;

  apr_step u_step (
    .item  (s1_item_r),
    .cfg   (cfg_r),
    .integ (integ_r),
    .step  (step)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.kp_raise <= '0;
      cfg_r.kp_lower <= '0;
      cfg_r.ki_raise <= '0;
      cfg_r.ki_lower <= '0;
      cfg_r.out_min  <= {1'b1, {(DRV_W-1){1'b0}}};
      cfg_r.out_max  <= {1'b0, {(DRV_W-1){1'b1}}};
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_KP_RAISE: cfg_r.kp_raise <= cfg_wdata[GAIN_W-1:0];
        CFG_KP_LOWER: cfg_r.kp_lower <= cfg_wdata[GAIN_W-1:0];
        CFG_KI_RAISE: cfg_r.ki_raise <= cfg_wdata[GAIN_W-1:0];
        CFG_KI_LOWER: cfg_r.ki_lower <= cfg_wdata[GAIN_W-1:0];
        CFG_OUT_MIN:  cfg_r.out_min  <= cfg_wdata[DRV_W-1:0];
        CFG_OUT_MAX:  cfg_r.out_max  <= cfg_wdata[DRV_W-1:0];
        default: ;  // unused indexes are ignored
      endcase
    end
  end

  // control: valids and integrator
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
    end else begin
      if (in_xfer) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        integ_r     <= step.integ;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_item_r <= in_data;
    end
    if (advance) begin
      out_item_r <= step.res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

endmodule
